// ===== rtl/optb_pkg.sv =====
// Package: shared types, codes and sizes of the timer bank.
`default_nettype none
package optb_pkg;

	localparam int SLOTS      = 8;
	localparam int TIME_WIDTH = 32;
	localparam int PERIOD_W   = 32;
	localparam int FIRE_W     = 8;
	localparam int SLOT_W     = 3;
	localparam int FUNC_W     = 3;
	localparam int POS_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W      = (POS_W > SLOT_W) ? POS_W : SLOT_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK      = 3'd0,
		FN_START_ONE = 3'd1,
		FN_START_PER = 3'd2,
		FN_STOP_ONE  = 3'd3,
		FN_STOP_PER  = 3'd4
	} func_e_t;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [SLOT_W-1:0]   slot;
		logic [PERIOD_W-1:0] period;
	} cmd_t;

	typedef struct packed {
		logic [FIRE_W-1:0] oneshot_fired;
		logic [FIRE_W-1:0] periodic_fired;
		logic              refused;
	} rsp_t;

	// Transaction travelling down the cell chain.
	typedef struct packed {
		logic [FUNC_W-1:0]     func;
		logic [SLOT_W-1:0]     slot;
		logic [PERIOD_W-1:0]   period;
		logic [TIME_WIDTH-1:0] now;
		logic [POS_W-1:0]      pos;
		logic [FIRE_W-1:0]     fired_one;
		logic [FIRE_W-1:0]     fired_per;
		logic                  refused;
	} token_t;

endpackage
`default_nettype wire

// ===== rtl/oneshot_and_periodic_timer_bank_unit.sv =====
// Top level: timer bank built as a chain of slot cells with a two-entry result queue.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  cmd     | in  | cmd_valid / cmd_stall | func, slot, period
//  rsp     | out | rsp_valid / rsp_stall | oneshot_fired, periodic_fired, refused
//
// A command transaction enters the chain at the head, moves one cell per cycle
// and is pushed into the result queue at the tail; the next command is taken
// only after that push, so the chain length sets the command rate.
// One command is in the chain at a time.
// Reset (arst_n low, asynchronous) stops every slot and zeroes the time count.
// A stalled result waits in the queue; one more command is taken meanwhile and
// cmd_stall rises only while a command is in the chain or the queue is full.
`default_nettype none
module oneshot_and_periodic_timer_bank_unit
	import optb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// Time counter, advanced when a tick is accepted.
	logic [TIME_WIDTH-1:0] now_q;
	logic                  inflight_q;

	// Chain links: link k feeds cell k; link SLOTS is the tail.
	logic   link_valid [SLOTS+1];
	token_t link       [SLOTS+1];

	logic   head_valid_q;
	token_t head_q;

	// Result queue: entry a is shown on the port, b holds the overflow.
	logic a_valid_q;
	logic b_valid_q;
	rsp_t a_q;
	rsp_t b_q;

	logic accept;
	logic push;
	logic pop;
	rsp_t tail_rsp;
	logic [TIME_WIDTH-1:0] now_next;

	assign cmd_stall = inflight_q || b_valid_q;
	assign accept    = cmd_valid && !cmd_stall;
	assign now_next  = (cmd.func == FN_TICK) ? TIME_WIDTH'(now_q + 1'b1) : now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			inflight_q   <= 1'b0;
			head_valid_q <= 1'b0;
		end else begin
			head_valid_q <= accept;
			if (accept) begin
				now_q      <= now_next;
				inflight_q <= 1'b1;
			end else if (push) begin
				inflight_q <= 1'b0;
			end
		end
	end

	// Load the transaction with the time it acts at and empty fire vectors.
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q.func      <= cmd.func;
			head_q.slot      <= cmd.slot;
			head_q.period    <= cmd.period;
			head_q.now       <= now_next;
			head_q.pos       <= '0;
			head_q.fired_one <= '0;
			head_q.fired_per <= '0;
			head_q.refused   <= 1'b0;
		end
	end

	assign link_valid[0] = head_valid_q;
	assign link[0]       = head_q;

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		optb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (link_valid[k]),
			.prev       (link[k]),
			.next_valid (link_valid[k+1]),
			.next       (link[k+1])
		);
	end

	assign push = link_valid[SLOTS];
	assign pop  = a_valid_q && !rsp_stall;

	assign tail_rsp.oneshot_fired  = link[SLOTS].fired_one;
	assign tail_rsp.periodic_fired = link[SLOTS].fired_per;
	assign tail_rsp.refused        = link[SLOTS].refused;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else begin
			case ({push, pop})
				2'b10: begin
					if (a_valid_q) begin
						b_valid_q <= 1'b1;
					end else begin
						a_valid_q <= 1'b1;
					end
				end
				2'b01: begin
					if (b_valid_q) begin
						b_valid_q <= 1'b0;
					end else begin
						a_valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (a_valid_q) begin
					b_q <= tail_rsp;
				end else begin
					a_q <= tail_rsp;
				end
			end
			2'b01: begin
				if (b_valid_q) begin
					a_q <= b_q;
				end
			end
			2'b11: begin
				if (b_valid_q) begin
					a_q <= b_q;
					b_q <= tail_rsp;
				end else begin
					a_q <= tail_rsp;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = a_valid_q;
	assign rsp       = a_q;

endmodule
`default_nettype wire

// ===== rtl/optb_cell.sv =====
// Cell: state of one timer slot, updated as a transaction passes by.
`default_nettype none
module optb_cell
	import optb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   prev_valid,
	input  wire token_t prev,
	output logic        next_valid,
	output token_t      next
);

	logic                  os_run_q;
	logic [PERIOD_W-1:0]   os_delay_q;
	logic [TIME_WIDTH-1:0] os_start_q;
	logic                  pr_run_q;
	logic [PERIOD_W-1:0]   pr_len_q;
	logic [TIME_WIDTH-1:0] pr_last_q;

	logic                  match;
	logic [TIME_WIDTH-1:0] os_elapsed;
	logic [TIME_WIDTH-1:0] pr_elapsed;
	logic                  is_tick;
	logic                  os_fire;
	logic                  pr_fire;
	logic [FIRE_W-1:0]     bit_mask;
	token_t                tok_d;

	assign is_tick    = prev_valid && (prev.func == FN_TICK);
	assign match      = prev_valid && (CMP_W'(prev.slot) == CMP_W'(prev.pos));
	assign os_elapsed = prev.now - os_start_q;
	assign pr_elapsed = prev.now - pr_last_q;
	assign os_fire    = is_tick && os_run_q && (PERIOD_W'(os_elapsed) >= os_delay_q);
	assign pr_fire    = is_tick && pr_run_q && (PERIOD_W'(pr_elapsed) >= pr_len_q);
	// Positions at or above the fire width shift out to zero.
	assign bit_mask   = FIRE_W'(1) << prev.pos;

	always_comb begin
		tok_d     = prev;
		tok_d.pos = POS_W'(prev.pos + 1'b1);
		if (os_fire) begin
			tok_d.fired_one = prev.fired_one | bit_mask;
		end
		if (pr_fire) begin
			tok_d.fired_per = prev.fired_per | bit_mask;
		end
		if (match && (prev.func == FN_START_ONE) && os_run_q) begin
			tok_d.refused = 1'b1;
		end
		if (match && (prev.func == FN_START_PER) && pr_run_q) begin
			tok_d.refused = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			os_run_q   <= 1'b0;
			os_delay_q <= '0;
			os_start_q <= '0;
			pr_run_q   <= 1'b0;
			pr_len_q   <= '0;
			pr_last_q  <= '0;
		end else begin
			if (os_fire) begin
				os_run_q   <= 1'b0;
				os_delay_q <= '0;
				os_start_q <= '0;
			end
			if (pr_fire) begin
				pr_last_q <= prev.now;
			end
			if (match) begin
				case (prev.func)
					FN_START_ONE: begin
						if (!os_run_q) begin
							os_run_q   <= 1'b1;
							os_delay_q <= prev.period;
							os_start_q <= prev.now;
						end
					end
					FN_START_PER: begin
						if (!pr_run_q) begin
							pr_run_q  <= 1'b1;
							pr_len_q  <= prev.period;
							pr_last_q <= prev.now;
						end
					end
					FN_STOP_ONE: begin
						os_run_q   <= 1'b0;
						os_delay_q <= '0;
						os_start_q <= '0;
					end
					FN_STOP_PER: begin
						pr_run_q  <= 1'b0;
						pr_len_q  <= '0;
						pr_last_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid <= 1'b0;
		end else begin
			next_valid <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		next <= tok_d;
	end

endmodule
`default_nettype wire
